// File: hdl/pfx_pkg.sv
// pfx_pkg: shared types and constants for the postfix expression evaluator
// used by pfx_alu, pfx_stack and postfix_expression_evaluator_top; no dependencies

package pfx_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int OUT_WIDTH       = 32;
    localparam int SYM_WIDTH       = 8;

    // operator and digit characters
    localparam logic [SYM_WIDTH-1:0] SYM_ADD  = 8'h2B;
    localparam logic [SYM_WIDTH-1:0] SYM_SUB  = 8'h2D;
    localparam logic [SYM_WIDTH-1:0] SYM_MUL  = 8'h2A;
    localparam logic [SYM_WIDTH-1:0] SYM_DIV  = 8'h2F;
    localparam logic [SYM_WIDTH-1:0] SYM_ZERO = 8'h30;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_UNDER = 2'd1,
        STAT_OVER  = 2'd2,
        STAT_DIV0  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDSUB,
        PH_ABS_A,
        PH_ABS_B,
        PH_MUL,
        PH_DIV,
        PH_FIX,
        PH_DONE
    } alu_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_LHS,
        ST_START,
        ST_WAIT,
        ST_END,
        ST_RESULT
    } ctrl_state_t;

endpackage

// File: hdl/pfx_stack.sv
// pfx_stack: value stack storage, one write port and one registered read port
// parameter defaults come from pfx_pkg

module pfx_stack #(
    parameter int DEPTH = pfx_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH = pfx_pkg::VALUE_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/pfx_alu.sv
// pfx_alu: iterative arithmetic unit built around one shared adder
// add/sub in one pass, multiply by shift-add, divide by restoring steps; uses pfx_pkg

module pfx_alu #(
    parameter int WIDTH = pfx_pkg::VALUE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pfx_pkg::alu_req_t  req,
    input  logic [WIDTH-1:0]   lhs,
    input  logic [WIDTH-1:0]   rhs,
    output logic               done,
    output logic [WIDTH-1:0]   result
);

    localparam int CNT_W = $clog2(WIDTH);

    pfx_pkg::alu_phase_t phase_reg, phase_next;
    pfx_pkg::alu_op_t    op_reg, op_next;
    logic [WIDTH-1:0]    a_reg, a_next;
    logic [WIDTH-1:0]    b_reg, b_next;
    logic [WIDTH-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                neg_reg, neg_next;

    // shared adder, one bit wider than the operands plus carry out
    logic [WIDTH:0]   add_x, add_y;
    logic             add_cin;
    logic [WIDTH+1:0] add_sum;
    logic             last_step;

    assign add_sum   = {1'b0, add_x} + {1'b0, add_y} + (WIDTH+2)'(add_cin);
    assign last_step = (cnt_reg == CNT_W'(WIDTH - 1));

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            pfx_pkg::PH_IDLE:
            begin
                if (req.start)
                begin
                    unique case (req.op)
                        pfx_pkg::ALU_ADD: phase_next = pfx_pkg::PH_ADDSUB;
                        pfx_pkg::ALU_SUB: phase_next = pfx_pkg::PH_ADDSUB;
                        pfx_pkg::ALU_MUL: phase_next = pfx_pkg::PH_MUL;
                        pfx_pkg::ALU_DIV: phase_next = pfx_pkg::PH_ABS_A;
                        default:          phase_next = pfx_pkg::PH_IDLE;
                    endcase
                end
            end
            pfx_pkg::PH_ADDSUB: phase_next = pfx_pkg::PH_DONE;
            pfx_pkg::PH_ABS_A:  phase_next = pfx_pkg::PH_ABS_B;
            pfx_pkg::PH_ABS_B:  phase_next = pfx_pkg::PH_DIV;
            pfx_pkg::PH_MUL:    phase_next = last_step ? pfx_pkg::PH_DONE : pfx_pkg::PH_MUL;
            pfx_pkg::PH_DIV:    phase_next = last_step ? pfx_pkg::PH_FIX : pfx_pkg::PH_DIV;
            pfx_pkg::PH_FIX:    phase_next = pfx_pkg::PH_DONE;
            pfx_pkg::PH_DONE:   phase_next = pfx_pkg::PH_IDLE;
            default:            phase_next = pfx_pkg::PH_IDLE;
        endcase
    end

    always_comb
    begin
        op_next  = op_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        add_x    = '0;
        add_y    = '0;
        add_cin  = 1'b0;
        unique case (phase_reg)
            pfx_pkg::PH_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    a_next   = lhs;
                    b_next   = rhs;
                    acc_next = '0;
                    cnt_next = '0;
                    neg_next = lhs[WIDTH-1] ^ rhs[WIDTH-1];
                end
            end
            pfx_pkg::PH_ADDSUB:
            begin
                add_x = {1'b0, a_reg};
                if (op_reg == pfx_pkg::ALU_SUB)
                begin
                    add_y   = {1'b0, ~b_reg};
                    add_cin = 1'b1;
                end
                else
                begin
                    add_y = {1'b0, b_reg};
                end
                acc_next = add_sum[WIDTH-1:0];
            end
            pfx_pkg::PH_ABS_A:
            begin
                add_y   = {1'b0, ~a_reg};
                add_cin = 1'b1;
                if (a_reg[WIDTH-1])
                begin
                    a_next = add_sum[WIDTH-1:0];
                end
            end
            pfx_pkg::PH_ABS_B:
            begin
                add_y   = {1'b0, ~b_reg};
                add_cin = 1'b1;
                if (b_reg[WIDTH-1])
                begin
                    b_next = add_sum[WIDTH-1:0];
                end
            end
            pfx_pkg::PH_MUL:
            begin
                add_x    = {1'b0, acc_reg};
                add_y    = b_reg[0] ? {1'b0, a_reg} : '0;
                acc_next = add_sum[WIDTH-1:0];
                a_next   = {a_reg[WIDTH-2:0], 1'b0};
                b_next   = {1'b0, b_reg[WIDTH-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            pfx_pkg::PH_DIV:
            begin
                // trial subtract of the divisor from the shifted remainder
                add_x   = {acc_reg, a_reg[WIDTH-1]};
                add_y   = ~{1'b0, b_reg};
                add_cin = 1'b1;
                if (add_sum[WIDTH+1])
                begin
                    acc_next = add_sum[WIDTH-1:0];
                end
                else
                begin
                    acc_next = add_x[WIDTH-1:0];
                end
                a_next   = {a_reg[WIDTH-2:0], add_sum[WIDTH+1]};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            pfx_pkg::PH_FIX:
            begin
                add_y   = {1'b0, ~a_reg};
                add_cin = 1'b1;
                acc_next = neg_reg ? add_sum[WIDTH-1:0] : a_reg;
            end
            pfx_pkg::PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pfx_pkg::PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign done   = (phase_reg == pfx_pkg::PH_DONE);
    assign result = acc_reg;

endmodule

// File: hdl/postfix_expression_evaluator_top.sv
// postfix_expression_evaluator_top: sequencer, stack pointer and result register
// instantiates pfx_stack and pfx_alu; uses pfx_pkg
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+-------------------------------
//  item     | item_valid, item_ready, symbol, last      | one character per transfer
//  result   | result_valid, result_ready, value, status | one transfer per last item
//
// multiply and divide items take longest, since the shared alu retires one
// multiplier or quotient bit per cycle. item_ready is high only while the
// sequencer is idle; a finished result waits in its output register while the
// next items are taken, and a last item stalls only if the previous result is
// still not taken. reset clears stack pointer, error status and result valid;
// stack contents stay undefined.

module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = pfx_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic [pfx_pkg::SYM_WIDTH-1:0]      symbol,
    input  logic                               last,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [pfx_pkg::OUT_WIDTH-1:0] value,
    output logic [1:0]                         status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    pfx_pkg::ctrl_state_t state_reg, state_next;
    logic [pfx_pkg::SYM_WIDTH-1:0] sym_reg, sym_next;
    logic                          last_reg, last_next;
    logic [CW-1:0]                 count_reg, count_next;
    pfx_pkg::status_t              err_reg, err_next;
    logic [VALUE_WIDTH-1:0]        rhs_reg, rhs_next;
    logic signed [pfx_pkg::OUT_WIDTH-1:0] value_reg, value_next;
    pfx_pkg::status_t              status_reg, status_next;
    logic                          out_valid_reg, out_valid_next;

    logic                   wr_en, rd_en;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [VALUE_WIDTH-1:0] wr_data, rd_data;
    logic signed [VALUE_WIDTH-1:0] top_s;

    pfx_pkg::alu_req_t      alu_req;
    pfx_pkg::alu_op_t       sym_op;
    logic                   alu_done;
    logic [VALUE_WIDTH-1:0] alu_result;

    logic                   is_op;
    logic                   can_pop;
    logic [CW-1:0]          count_m1, count_m2;
    logic signed [pfx_pkg::SYM_WIDTH:0] push_val;
    pfx_pkg::status_t       final_status;

    pfx_stack #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pfx_alu #(
        .WIDTH (VALUE_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .lhs    (rd_data),
        .rhs    (rhs_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    assign is_op = (sym_reg == pfx_pkg::SYM_ADD) || (sym_reg == pfx_pkg::SYM_SUB) ||
                   (sym_reg == pfx_pkg::SYM_MUL) || (sym_reg == pfx_pkg::SYM_DIV);
    assign can_pop  = (count_reg >= CW'(2));
    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign push_val = $signed({1'b0, sym_reg}) - $signed({1'b0, pfx_pkg::SYM_ZERO});
    assign top_s    = rd_data;

    always_comb
    begin
        unique case (sym_reg)
            pfx_pkg::SYM_SUB: sym_op = pfx_pkg::ALU_SUB;
            pfx_pkg::SYM_MUL: sym_op = pfx_pkg::ALU_MUL;
            pfx_pkg::SYM_DIV: sym_op = pfx_pkg::ALU_DIV;
            default:          sym_op = pfx_pkg::ALU_ADD;
        endcase
    end

    // empty stack at the end of an error-free expression counts as underflow
    always_comb
    begin
        if (err_reg != pfx_pkg::STAT_OK)
        begin
            final_status = err_reg;
        end
        else if (count_reg == '0)
        begin
            final_status = pfx_pkg::STAT_UNDER;
        end
        else
        begin
            final_status = pfx_pkg::STAT_OK;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfx_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = pfx_pkg::ST_DECODE;
                end
            end
            pfx_pkg::ST_DECODE:
            begin
                if ((err_reg == pfx_pkg::STAT_OK) && is_op && can_pop)
                begin
                    state_next = pfx_pkg::ST_RD_LHS;
                end
                else
                begin
                    state_next = pfx_pkg::ST_END;
                end
            end
            pfx_pkg::ST_RD_LHS: state_next = pfx_pkg::ST_START;
            pfx_pkg::ST_START:
            begin
                if ((sym_op == pfx_pkg::ALU_DIV) && (rhs_reg == '0))
                begin
                    state_next = pfx_pkg::ST_END;
                end
                else
                begin
                    state_next = pfx_pkg::ST_WAIT;
                end
            end
            pfx_pkg::ST_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = pfx_pkg::ST_END;
                end
            end
            pfx_pkg::ST_END:
            begin
                if (!last_reg)
                begin
                    state_next = pfx_pkg::ST_IDLE;
                end
                else if (!out_valid_reg)
                begin
                    state_next = pfx_pkg::ST_RESULT;
                end
            end
            pfx_pkg::ST_RESULT: state_next = pfx_pkg::ST_IDLE;
            default:            state_next = pfx_pkg::ST_IDLE;
        endcase
    end

    // datapath and stack control
    always_comb
    begin
        sym_next       = sym_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        rhs_next       = rhs_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg & ~result_ready;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = alu_result;
        rd_en          = 1'b0;
        rd_addr        = count_m1[AW-1:0];
        alu_req.start  = 1'b0;
        alu_req.op     = sym_op;
        unique case (state_reg)
            pfx_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    sym_next  = symbol;
                    last_next = last;
                end
            end
            pfx_pkg::ST_DECODE:
            begin
                if (err_reg == pfx_pkg::STAT_OK)
                begin
                    if (is_op)
                    begin
                        if (can_pop)
                        begin
                            rd_en = 1'b1;
                        end
                        else
                        begin
                            err_next = pfx_pkg::STAT_UNDER;
                        end
                    end
                    else if (count_reg == CW'(STACK_DEPTH))
                    begin
                        err_next = pfx_pkg::STAT_OVER;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_data    = VALUE_WIDTH'(push_val);
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            pfx_pkg::ST_RD_LHS:
            begin
                rhs_next = rd_data;
                rd_en    = 1'b1;
                rd_addr  = count_m2[AW-1:0];
            end
            pfx_pkg::ST_START:
            begin
                count_next = count_m2;
                if ((sym_op == pfx_pkg::ALU_DIV) && (rhs_reg == '0))
                begin
                    err_next = pfx_pkg::STAT_DIV0;
                end
                else
                begin
                    alu_req.start = 1'b1;
                end
            end
            pfx_pkg::ST_WAIT:
            begin
                if (alu_done)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            pfx_pkg::ST_END:
            begin
                if (last_reg && !out_valid_reg)
                begin
                    rd_en = 1'b1;
                end
            end
            pfx_pkg::ST_RESULT:
            begin
                status_next    = final_status;
                value_next     = (final_status == pfx_pkg::STAT_OK) ?
                                 pfx_pkg::OUT_WIDTH'(top_s) : '0;
                out_valid_next = 1'b1;
                count_next     = '0;
                err_next       = pfx_pkg::STAT_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfx_pkg::ST_IDLE;
            count_reg     <= '0;
            err_reg       <= pfx_pkg::STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg    <= sym_next;
        last_reg   <= last_next;
        rhs_reg    <= rhs_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign item_ready   = (state_reg == pfx_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign value        = value_reg;
    assign status       = status_reg;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for postfix_expression_evaluator_top, with an expression
// predictor and result scoreboard in a small class; depends on pfx_pkg and the hdl sources

module tb;

    localparam int DEPTH         = pfx_pkg::STACK_DEPTH_DEF;
    localparam int VW            = pfx_pkg::VALUE_WIDTH_DEF;
    localparam int SYM_WIDTH     = pfx_pkg::SYM_WIDTH;
    localparam int OUT_WIDTH     = pfx_pkg::OUT_WIDTH;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int ITEM_TARGET   = 850;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] value;
        pfx_pkg::status_t            status;
    } eval_result_t;

    class expr_scoreboard;
        logic [VW-1:0]    operands[DEPTH];
        int unsigned      used;
        pfx_pkg::status_t fault;
        eval_result_t     pending_q[$];
        int unsigned      errors;

        function new();
            used   = 0;
            fault  = pfx_pkg::STAT_OK;
            errors = 0;
        endfunction

        function void push_operand(logic [VW-1:0] v);
            if (used >= DEPTH)
                fault = pfx_pkg::STAT_OVER;
            else
            begin
                operands[used] = v;
                used++;
            end
        endfunction

        function void note_item(logic [SYM_WIDTH-1:0] sym, logic lst);
            logic [VW-1:0] lhs, rhs, mag_l, mag_r, quo;
            eval_result_t  res;
            if (fault == pfx_pkg::STAT_OK)
            begin
                if (sym inside {pfx_pkg::SYM_ADD, pfx_pkg::SYM_SUB,
                                pfx_pkg::SYM_MUL, pfx_pkg::SYM_DIV})
                begin
                    if (used < 2)
                        fault = pfx_pkg::STAT_UNDER;
                    else
                    begin
                        rhs  = operands[used-1];
                        lhs  = operands[used-2];
                        used = used - 2;
                        case (sym)
                            pfx_pkg::SYM_ADD: push_operand(lhs + rhs);
                            pfx_pkg::SYM_SUB: push_operand(lhs - rhs);
                            pfx_pkg::SYM_MUL: push_operand(lhs * rhs);
                            default:
                            begin
                                if (rhs == '0)
                                    fault = pfx_pkg::STAT_DIV0;
                                else
                                begin
                                    // magnitudes, then sign: truncates toward zero
                                    mag_l = lhs[VW-1] ? -lhs : lhs;
                                    mag_r = rhs[VW-1] ? -rhs : rhs;
                                    quo   = mag_l / mag_r;
                                    if (lhs[VW-1] ^ rhs[VW-1])
                                        quo = -quo;
                                    push_operand(quo);
                                end
                            end
                        endcase
                    end
                end
                else
                    push_operand({{(VW-SYM_WIDTH){1'b0}}, sym} - VW'(pfx_pkg::SYM_ZERO));
            end
            if (lst)
            begin
                res.status = fault;
                res.value  = '0;
                if (fault == pfx_pkg::STAT_OK)
                begin
                    if (used == 0)
                        res.status = pfx_pkg::STAT_UNDER;
                    else
                        res.value = operands[used-1];
                end
                pending_q.push_back(res);
                used  = 0;
                fault = pfx_pkg::STAT_OK;
            end
        endfunction

        function void check_result(logic signed [OUT_WIDTH-1:0] v, logic [1:0] s);
            eval_result_t want;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: value %0d status %0d", $time, v, s);
            end
            else
            begin
                want = pending_q.pop_front();
                if (v !== want.value)
                begin
                    errors++;
                    $display("%0t: value mismatch: expected %0d actual %0d",
                             $time, want.value, v);
                end
                if (s !== want.status)
                begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, s);
                end
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        item_valid;
    logic                        item_ready;
    logic [SYM_WIDTH-1:0]        symbol;
    logic                        last;
    logic                        result_valid;
    logic                        result_ready;
    logic signed [OUT_WIDTH-1:0] value;
    logic [1:0]                  status;

    expr_scoreboard       sb = new();
    logic [SYM_WIDTH-1:0] expr_syms[$];
    bit                   tx_idle_en = 1'b1;
    bit                   rx_idle_en = 1'b1;
    bit                   hold_req   = 1'b0;
    int                   hold_left  = 0;
    int unsigned          sent_items = 0;
    int unsigned          cycle_count = 0;

    postfix_expression_evaluator_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .symbol       (symbol),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value),
        .status       (status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [SYM_WIDTH-1:0] digit(int n);
        return pfx_pkg::SYM_ZERO + SYM_WIDTH'(n);
    endfunction

    function automatic logic [SYM_WIDTH-1:0] random_op();
        case ($urandom_range(3))
            0:       return pfx_pkg::SYM_ADD;
            1:       return pfx_pkg::SYM_SUB;
            2:       return pfx_pkg::SYM_MUL;
            default: return pfx_pkg::SYM_DIV;
        endcase
    endfunction

    // mostly decimal digits, sometimes any non-operator byte
    function automatic logic [SYM_WIDTH-1:0] random_operand();
        logic [SYM_WIDTH-1:0] s;
        if ($urandom_range(4) != 0)
            return digit($urandom_range(9));
        do
            s = SYM_WIDTH'($urandom_range(255));
        while (s inside {pfx_pkg::SYM_ADD, pfx_pkg::SYM_SUB,
                         pfx_pkg::SYM_MUL, pfx_pkg::SYM_DIV});
        return s;
    endfunction

    task automatic send_item(input logic [SYM_WIDTH-1:0] sym, input logic lst);
        while (tx_idle_en && $urandom_range(99) < 32)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        symbol     = sym;
        last       = lst;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_item(sym, lst);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic send_expr();
        for (int i = 0; i < expr_syms.size(); i++)
            send_item(expr_syms[i], i == expr_syms.size() - 1);
    endtask

    task automatic drain();
        item_valid = 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
    endtask

    // well-formed expression; flood pushes everything first to run past the stack
    task automatic build_expr(input int pushes, input bit flood);
        int depth;
        int left;
        depth     = 0;
        left      = pushes;
        expr_syms = {};
        while (left > 0 || depth > 1)
        begin
            if (depth >= 2 && (left == 0 || (!flood && $urandom_range(99) < 45)))
            begin
                expr_syms.push_back(random_op());
                depth--;
            end
            else
            begin
                expr_syms.push_back(random_operand());
                depth++;
                left--;
            end
        end
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready = 1'b0;
            end
            else
                result_ready = !(rx_idle_en && $urandom_range(99) < 32);
        end
    end

    always @(posedge clk)
        if (result_valid && result_ready)
            sb.check_result(value, status);

    initial
    begin
        int exprs;
        int kind;
        int len;
        int waited;
        item_valid = 1'b0;
        symbol     = '0;
        last       = 1'b0;
        rst_n      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extreme symbols: -48 + 207
        expr_syms = {8'h00, 8'hFF, pfx_pkg::SYM_ADD};
        send_expr();
        // build the most negative value, then divide it by -1
        expr_syms = {digit(128), digit(128), pfx_pkg::SYM_MUL, digit(128), pfx_pkg::SYM_MUL,
                     digit(128), pfx_pkg::SYM_MUL, digit(8), pfx_pkg::SYM_MUL, digit(0),
                     digit(1), pfx_pkg::SYM_SUB, pfx_pkg::SYM_DIV};
        send_expr();
        // operator on an empty stack
        expr_syms = {pfx_pkg::SYM_MUL};
        send_expr();
        // divide by zero, later symbols ignored
        expr_syms = {digit(5), digit(0), pfx_pkg::SYM_DIV, digit(7), pfx_pkg::SYM_SUB};
        send_expr();
        // negative quotient truncates toward zero: 7 / -2
        expr_syms = {digit(7), 8'h2E, pfx_pkg::SYM_DIV};
        send_expr();

        // receiver holds off while single-digit expressions pile up
        drain();
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            expr_syms = {digit(i)};
            send_expr();
        end
        drain();

        exprs = 0;
        while (sent_items < ITEM_TARGET)
        begin
            exprs++;
            tx_idle_en = !(exprs >= 60 && exprs < 100);
            rx_idle_en = tx_idle_en;
            kind = $urandom_range(99);
            if (kind < 75)
            begin
                build_expr($urandom_range(1, 8), 1'b0);
                send_expr();
            end
            else if (kind < 82)
            begin
                build_expr($urandom_range(DEPTH + 1, DEPTH + 4), 1'b1);
                send_expr();
            end
            else if (kind < 94)
            begin
                // broken: operators and operands in random order
                len       = $urandom_range(1, 6);
                expr_syms = {};
                for (int i = 0; i < len; i++)
                    expr_syms.push_back($urandom_range(1) ? random_op() : random_operand());
                send_expr();
            end
            else
                send_item(SYM_WIDTH'($urandom_range(255)), 1'($urandom_range(1)));
            if ($urandom_range(49) == 0)
                drain();
        end
        // close any expression left open by a noise transfer
        expr_syms = {digit(3)};
        send_expr();
        item_valid = 1'b0;

        waited = 0;
        while (sb.pending_q.size() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.pending_q.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.pending_q.size());
        end

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
